@@ sv/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// nsc_pkg: shared definitions for the nested size token checker
// Error codes, field widths and the control bundle that drives the stack cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

  localparam int TOKEN_W = 16;
  localparam int ERR_W   = 3;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MISMATCH  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_CAPACITY  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNCLOSED  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd5;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/nsc_cell.sv @@
// ----------------------------------------------------------------------------
// nsc_cell: one stack position
// Holds one (size, child sum) entry. On a push it takes the entry from the
// cell above, on a pop the entry from the cell below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsc_cell #(
  parameter int SIZE_BITS = 15
) (
  input  wire logic                   clk,
  input  wire nsc_pkg::cell_ctl_t     ctl,
  input  wire logic [2*SIZE_BITS-1:0] up_i,
  input  wire logic [2*SIZE_BITS-1:0] dn_i,
  output logic      [2*SIZE_BITS-1:0] q_o
);

  logic [2*SIZE_BITS-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry_r <= up_i;
    end else if (ctl.pop) begin
      entry_r <= dn_i;
    end
  end

  assign q_o = entry_r;

endmodule

`default_nettype wire

@@ sv/nested_size_token_checker.sv @@
// ----------------------------------------------------------------------------
// nested_size_token_checker: nesting and capacity check over signed tokens
// Usage:
//   Input channel (in_valid / in_stall, in_token, in_last): one token per
//   request. A negative token opens an element of size -token, zero or
//   positive closes the innermost one. in_last marks the end of a sequence.
//   Result channel (out_valid / out_stall, out_valid_res, out_error_kind):
//   one result per sequence, issued for the token that carries in_last.
//   Throughput: one token per cycle while in_stall is low. The stack is a row of STACK_DEPTH cells
//   that all shift on a push or pop, so the top two entries are always at
//   hand and every token finishes in the cycle it is accepted.
//   Result: the result of the last token is registered in the result
//   register behind the out_ ports, or in the skid entry while the receiver stalls.
//   Stalls: a result register plus one skid entry hold results while the
//   receiver stalls; tokens keep flowing until both are full, then in_stall
//   rises until out_stall drops.
//   Reset: clears the open count, the error and both result valid bits. Stack
//   cells are not cleared; only entries below the open count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nested_size_token_checker #(
  parameter int STACK_DEPTH = 1024,
  parameter int SIZE_BITS   = 15
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [nsc_pkg::TOKEN_W-1:0] in_token,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_valid_res,
  output logic             [nsc_pkg::ERR_W-1:0]  out_error_kind
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = 2 * SIZE_BITS;
  localparam int W  = ((SIZE_BITS > nsc_pkg::TOKEN_W) ? SIZE_BITS : nsc_pkg::TOKEN_W) + 1;
  localparam logic [W-1:0]  SMAX  = W'((64'd1 << SIZE_BITS) - 64'd1);
  localparam logic [CW-1:0] FULL  = CW'(STACK_DEPTH);

  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [nsc_pkg::ERR_W-1:0] err_r, err_nxt;
  logic                      out_v_r, out_v_nxt;
  logic                      out_res_r, out_res_nxt;
  logic [nsc_pkg::ERR_W-1:0] out_kind_r, out_kind_nxt;
  logic                      skid_v_r, skid_v_nxt;
  logic                      skid_res_r, skid_res_nxt;
  logic [nsc_pkg::ERR_W-1:0] skid_kind_r, skid_kind_nxt;

  logic [EW-1:0]             cell_q [STACK_DEPTH];
  nsc_pkg::cell_ctl_t        ctl;

  logic                      fire;
  logic [16:0]               mag;
  logic [W-1:0]              mag_w, tok_w, top_size_w, par_size_w, par_sum_w, sum_w;
  logic [EW-1:0]             push_entry, pop_entry;
  logic                      res_v;
  logic [nsc_pkg::ERR_W-1:0] res_kind;

  assign in_stall   = skid_v_r;
  assign fire       = in_valid && !in_stall;

  assign mag        = 17'h10000 - {1'b0, in_token};
  assign mag_w      = W'(mag);
  assign tok_w      = W'({1'b0, in_token});
  assign top_size_w = W'(cell_q[0][EW-1:SIZE_BITS]);
  assign par_size_w = W'(cell_q[1][EW-1:SIZE_BITS]);
  assign par_sum_w  = W'(cell_q[1][SIZE_BITS-1:0]);
  assign sum_w      = par_sum_w + tok_w;
  assign push_entry = {mag_w[SIZE_BITS-1:0], {SIZE_BITS{1'b0}}};
  assign pop_entry  = {cell_q[1][EW-1:SIZE_BITS], sum_w[SIZE_BITS-1:0]};

  always_comb begin
    ctl      = '0;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    res_v    = 1'b0;
    res_kind = nsc_pkg::ERR_NONE;
    if (fire) begin
      if (err_r == nsc_pkg::ERR_NONE) begin
        if (in_token[nsc_pkg::TOKEN_W-1]) begin
          if (mag_w > SMAX) begin
            err_nxt = nsc_pkg::ERR_CAPACITY;
          end else if (cnt_r == FULL) begin
            err_nxt = nsc_pkg::ERR_OVERFLOW;
          end else begin
            ctl.push = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
          end
        end else if (cnt_r == '0) begin
          err_nxt = nsc_pkg::ERR_UNMATCHED;
        end else if (top_size_w != tok_w) begin
          err_nxt = nsc_pkg::ERR_MISMATCH;
        end else if (cnt_r > CW'(1) && sum_w >= par_size_w) begin
          err_nxt = nsc_pkg::ERR_CAPACITY;
        end else begin
          ctl.pop = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      if (in_last) begin
        res_v    = 1'b1;
        res_kind = (err_nxt == nsc_pkg::ERR_NONE && cnt_nxt != '0) ?
                   nsc_pkg::ERR_UNCLOSED : err_nxt;
        cnt_nxt  = '0;
        err_nxt  = nsc_pkg::ERR_NONE;
      end
    end
  end

  // result register with one skid entry
  always_comb begin
    out_v_nxt     = out_v_r;
    out_res_nxt   = out_res_r;
    out_kind_nxt  = out_kind_r;
    skid_v_nxt    = skid_v_r;
    skid_res_nxt  = skid_res_r;
    skid_kind_nxt = skid_kind_r;
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_nxt    = 1'b1;
        out_res_nxt  = skid_res_r;
        out_kind_nxt = skid_kind_r;
        skid_v_nxt   = 1'b0;
      end else begin
        out_v_nxt    = res_v;
        out_res_nxt  = (res_kind == nsc_pkg::ERR_NONE);
        out_kind_nxt = res_kind;
      end
    end else if (res_v) begin
      skid_v_nxt    = 1'b1;
      skid_res_nxt  = (res_kind == nsc_pkg::ERR_NONE);
      skid_kind_nxt = res_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      err_r    <= nsc_pkg::ERR_NONE;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r   <= out_res_nxt;
    out_kind_r  <= out_kind_nxt;
    skid_res_r  <= skid_res_nxt;
    skid_kind_r <= skid_kind_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_valid_res  = out_res_r;
  assign out_error_kind = out_kind_r;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [EW-1:0] up_d, dn_d;
    if (i == 0) begin : g_top
      assign up_d = push_entry;
      assign dn_d = pop_entry;
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      assign up_d = cell_q[i-1];
      assign dn_d = cell_q[i];
    end else begin : g_mid
      assign up_d = cell_q[i-1];
      assign dn_d = cell_q[i+1];
    end
    nsc_cell #(
      .SIZE_BITS(SIZE_BITS)
    ) u_cell (
      .clk (clk),
      .ctl (ctl),
      .up_i(up_d),
      .dn_i(dn_d),
      .q_o (cell_q[i])
    );
  end

endmodule

`default_nettype wire
